### hw/rtl/wps_pkg.sv
// Shared types and constants of the WAV PCM stream parser.
// Holds the parser phase, the chunk and result codes, and the event record.
// No dependencies.
package wps_pkg;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_FSIZE,
		PH_WAVE,
		PH_CID,
		PH_CSIZE,
		PH_FMT,
		PH_SKIP,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		CK_OTHER,
		CK_FMT,
		CK_DATA
	} chunk_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNREC   = 2'd1,
		ST_CORRUPT = 2'd2
	} status_t;

	// Four-character tags, first character in the top byte
	localparam logic [31:0] TAG_RIFF = "RIFF";
	localparam logic [31:0] TAG_WAVE = "WAVE";
	localparam logic [31:0] TAG_FMT  = "fmt ";
	localparam logic [31:0] TAG_DATA = "data";

	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
	localparam logic [15:0] PCM_CODE     = 16'd1;
	localparam logic [7:0]  PCM8_BIAS    = 8'd128;

	// One parsed input byte: an optional sample or report, then an optional status
	typedef struct packed {
		logic        prim_valid;
		kind_t       prim_kind;
		logic [15:0] value;
		logic        chan;
		logic [31:0] rate;
		logic [1:0]  chans;
		logic [15:0] bits;
		logic        st_valid;
		status_t     st;
	} event_t;

	// Character of a tag at byte position pos
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] pos);
		return tag[{~pos, 3'b000} +: 8];
	endfunction

endpackage

### hw/rtl/wps_queue.sv
// Event queue between the parser front and the result back end.
// Small register file with read and write pointers and a fill count.
// Depends on wps_pkg for the event record.
module wps_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  wps_pkg::event_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output wps_pkg::event_t rd_data,
	output logic            empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wps_pkg::event_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store an incoming event
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/wps_front.sv
// Parser front end: walks RIFF/WAVE headers and chunks one byte per request.
// Turns each byte into at most one event record for the back end.
// Depends on wps_pkg for phases, codes, tags and the event record.
module wps_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            start_of_file,
	input  logic            end_of_file,
	output logic            ev_valid,
	output wps_pkg::event_t ev
);

	// Parser state
	wps_pkg::phase_t phase_q;
	wps_pkg::chunk_t ckind_q;
	logic [4:0]  pos_q;
	logic [31:0] shift_q;
	logic [31:0] rem_q;
	logic        fmt_seen_q;
	logic [1:0]  chans_q;
	logic [12:0] bps_q;
	logic [13:0] frame_q;
	logic [31:0] rate_q;
	logic        cur_ch_q;
	logic [12:0] sidx_q;
	logic [7:0]  low_q;
	logic        done_q;

	// State seen by this byte (cleared on start of file)
	wps_pkg::phase_t c_phase;
	wps_pkg::chunk_t c_ckind;
	logic [4:0]  c_pos;
	logic [31:0] c_shift;
	logic [31:0] c_rem;
	logic        c_fmt_seen;
	logic [1:0]  c_chans;
	logic [12:0] c_bps;
	logic [13:0] c_frame;
	logic [31:0] c_rate;
	logic        c_cur_ch;
	logic [12:0] c_sidx;
	logic [7:0]  c_low;
	logic        c_done;

	// Next state
	wps_pkg::phase_t phase_d;
	wps_pkg::chunk_t ckind_d;
	logic [4:0]  pos_d;
	logic [31:0] shift_d;
	logic [31:0] rem_d;
	logic        fmt_seen_d;
	logic [1:0]  chans_d;
	logic [12:0] bps_d;
	logic [13:0] frame_d;
	logic [31:0] rate_d;
	logic        cur_ch_d;
	logic [12:0] sidx_d;
	logic [7:0]  low_d;
	logic        done_d;

	logic [31:0] sh_new;
	logic [15:0] half;
	logic [1:0]  p2;
	logic [31:0] rem_dec;
	logic [7:0]  pcm8;
	logic        sample_end;
	logic        frame_end;

	assign sh_new  = {data_byte, c_shift[31:8]};
	assign half    = sh_new[31:16];
	assign p2      = c_pos[1:0];
	assign rem_dec = c_rem - 32'd1;
	assign pcm8    = data_byte - wps_pkg::PCM8_BIAS;
	assign sample_end = ({1'b0, c_sidx} + 14'd1) >= {1'b0, c_bps};
	assign frame_end  = sample_end && ((c_chans != 2'd2) || c_cur_ch);
	assign ev_valid   = ev.prim_valid || ev.st_valid;

	// Restart from the reset state on start of file
	always_comb begin
		if (start_of_file) begin
			c_phase    = wps_pkg::PH_RIFF;
			c_ckind    = wps_pkg::CK_OTHER;
			c_pos      = '0;
			c_shift    = '0;
			c_rem      = '0;
			c_fmt_seen = 1'b0;
			c_chans    = '0;
			c_bps      = '0;
			c_frame    = '0;
			c_rate     = '0;
			c_cur_ch   = 1'b0;
			c_sidx     = '0;
			c_low      = '0;
			c_done     = 1'b0;
		end else begin
			c_phase    = phase_q;
			c_ckind    = ckind_q;
			c_pos      = pos_q;
			c_shift    = shift_q;
			c_rem      = rem_q;
			c_fmt_seen = fmt_seen_q;
			c_chans    = chans_q;
			c_bps      = bps_q;
			c_frame    = frame_q;
			c_rate     = rate_q;
			c_cur_ch   = cur_ch_q;
			c_sidx     = sidx_q;
			c_low      = low_q;
			c_done     = done_q;
		end
	end

	// Classify the byte and compute the next parser state
	always_comb begin
		phase_d    = c_phase;
		ckind_d    = c_ckind;
		pos_d      = c_pos;
		shift_d    = c_shift;
		rem_d      = c_rem;
		fmt_seen_d = c_fmt_seen;
		chans_d    = c_chans;
		bps_d      = c_bps;
		frame_d    = c_frame;
		rate_d     = c_rate;
		cur_ch_d   = c_cur_ch;
		sidx_d     = c_sidx;
		low_d      = c_low;
		done_d     = c_done;
		ev         = '0;

		if (!c_done) begin
			shift_d = sh_new;
			unique case (c_phase)
				wps_pkg::PH_RIFF: begin
					if (data_byte != wps_pkg::tag_byte(wps_pkg::TAG_RIFF, p2)) begin
						ev.st_valid = 1'b1;
						ev.st       = wps_pkg::ST_UNREC;
					end else begin
						pos_d = {3'b000, p2 + 2'd1};
						if (p2 == 2'd3) begin
							phase_d = wps_pkg::PH_FSIZE;
						end
					end
				end
				wps_pkg::PH_FSIZE: begin
					pos_d = {3'b000, p2 + 2'd1};
					if (p2 == 2'd3) begin
						phase_d = wps_pkg::PH_WAVE;
					end
				end
				wps_pkg::PH_WAVE: begin
					if (data_byte != wps_pkg::tag_byte(wps_pkg::TAG_WAVE, p2)) begin
						ev.st_valid = 1'b1;
						ev.st       = wps_pkg::ST_UNREC;
					end else begin
						pos_d = {3'b000, p2 + 2'd1};
						if (p2 == 2'd3) begin
							phase_d = wps_pkg::PH_CID;
							pos_d   = '0;
							ckind_d = wps_pkg::CK_OTHER;
						end
					end
				end
				wps_pkg::PH_CID: begin
					if (p2 == 2'd0) begin
						if (data_byte == wps_pkg::tag_byte(wps_pkg::TAG_FMT, p2)) begin
							ckind_d = wps_pkg::CK_FMT;
						end else if (data_byte == wps_pkg::tag_byte(wps_pkg::TAG_DATA, p2)) begin
							ckind_d = wps_pkg::CK_DATA;
						end else begin
							ckind_d = wps_pkg::CK_OTHER;
						end
					end else if (c_ckind == wps_pkg::CK_FMT &&
						data_byte != wps_pkg::tag_byte(wps_pkg::TAG_FMT, p2)) begin
						ckind_d = wps_pkg::CK_OTHER;
					end else if (c_ckind == wps_pkg::CK_DATA &&
						data_byte != wps_pkg::tag_byte(wps_pkg::TAG_DATA, p2)) begin
						ckind_d = wps_pkg::CK_OTHER;
					end
					pos_d = {3'b000, p2 + 2'd1};
					if (p2 == 2'd3) begin
						phase_d = wps_pkg::PH_CSIZE;
					end
				end
				wps_pkg::PH_CSIZE: begin
					pos_d = {3'b000, p2 + 2'd1};
					if (p2 == 2'd3) begin
						if (c_ckind == wps_pkg::CK_FMT && !c_fmt_seen) begin
							// First fmt chunk: read it field by field
							if (sh_new < wps_pkg::FMT_MIN_SIZE) begin
								ev.st_valid = 1'b1;
								ev.st       = wps_pkg::ST_UNREC;
							end else begin
								rem_d   = sh_new;
								phase_d = wps_pkg::PH_FMT;
								pos_d   = '0;
							end
						end else if (c_ckind == wps_pkg::CK_DATA) begin
							if (!c_fmt_seen) begin
								ev.st_valid = 1'b1;
								ev.st       = wps_pkg::ST_CORRUPT;
							end else begin
								// Report the format, end at once if no whole frame
								ev.prim_valid = 1'b1;
								ev.prim_kind  = wps_pkg::KIND_REPORT;
								ev.rate       = c_rate;
								ev.chans      = c_chans;
								ev.bits       = {c_bps, 3'b000};
								if (sh_new < {18'd0, c_frame}) begin
									ev.st_valid = 1'b1;
									ev.st       = wps_pkg::ST_OK;
								end else begin
									rem_d    = sh_new;
									phase_d  = wps_pkg::PH_DATA;
									cur_ch_d = 1'b0;
									sidx_d   = '0;
								end
							end
						end else begin
							// Skip unknown chunks and any later fmt chunk
							rem_d = sh_new;
							if (sh_new == '0) begin
								phase_d = wps_pkg::PH_CID;
								pos_d   = '0;
								ckind_d = wps_pkg::CK_OTHER;
							end else begin
								phase_d = wps_pkg::PH_SKIP;
							end
						end
					end
				end
				wps_pkg::PH_FMT: begin
					rem_d = rem_dec;
					pos_d = c_pos + 5'd1;
					if (c_pos == 5'd1 && half != wps_pkg::PCM_CODE) begin
						ev.st_valid = 1'b1;
						ev.st       = wps_pkg::ST_UNREC;
					end else if (c_pos == 5'd3) begin
						if (half != 16'd1 && half != 16'd2) begin
							ev.st_valid = 1'b1;
							ev.st       = wps_pkg::ST_UNREC;
						end else begin
							chans_d = half[1:0];
						end
					end else if (c_pos == 5'd7) begin
						rate_d = sh_new;
					end else if (c_pos == 5'd15) begin
						if (half == '0 || half[2:0] != 3'd0) begin
							ev.st_valid = 1'b1;
							ev.st       = wps_pkg::ST_UNREC;
						end else begin
							bps_d      = half[15:3];
							frame_d    = (c_chans == 2'd2) ? {half[15:3], 1'b0} : {1'b0, half[15:3]};
							fmt_seen_d = 1'b1;
							if (rem_dec == '0) begin
								phase_d = wps_pkg::PH_CID;
								pos_d   = '0;
								ckind_d = wps_pkg::CK_OTHER;
							end else begin
								phase_d = wps_pkg::PH_SKIP;
							end
						end
					end
				end
				wps_pkg::PH_SKIP: begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = wps_pkg::PH_CID;
						pos_d   = '0;
						ckind_d = wps_pkg::CK_OTHER;
					end
				end
				wps_pkg::PH_DATA: begin
					rem_d = rem_dec;
					// Emit 8-bit samples at once, wider ones on their second byte
					if (c_bps == 13'd1) begin
						ev.prim_valid = 1'b1;
						ev.prim_kind  = wps_pkg::KIND_SAMPLE;
						ev.value      = {{8{pcm8[7]}}, pcm8};
						ev.chan       = c_cur_ch;
					end else if (c_sidx == 13'd0) begin
						low_d = data_byte;
					end else if (c_sidx == 13'd1) begin
						ev.prim_valid = 1'b1;
						ev.prim_kind  = wps_pkg::KIND_SAMPLE;
						ev.value      = {data_byte, c_low};
						ev.chan       = c_cur_ch;
					end
					if (sample_end) begin
						sidx_d = '0;
						if (c_chans == 2'd2) begin
							cur_ch_d = ~c_cur_ch;
						end
					end else begin
						sidx_d = c_sidx + 13'd1;
					end
					// Stop when less than a whole frame is left
					if (frame_end && rem_dec < {18'd0, c_frame}) begin
						ev.st_valid = 1'b1;
						ev.st       = wps_pkg::ST_OK;
					end
				end
				default: begin
					ev.st_valid = 1'b1;
					ev.st       = wps_pkg::ST_CORRUPT;
				end
			endcase

			// Early end of file
			if (!ev.st_valid && end_of_file) begin
				ev.st_valid = 1'b1;
				if (phase_d == wps_pkg::PH_RIFF || phase_d == wps_pkg::PH_FSIZE ||
					phase_d == wps_pkg::PH_WAVE) begin
					ev.st = wps_pkg::ST_UNREC;
				end else begin
					ev.st = wps_pkg::ST_CORRUPT;
				end
			end
			if (ev.st_valid) begin
				done_d = 1'b1;
			end
		end
	end

	// Update parser state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wps_pkg::PH_RIFF;
			ckind_q    <= wps_pkg::CK_OTHER;
			pos_q      <= '0;
			shift_q    <= '0;
			rem_q      <= '0;
			fmt_seen_q <= 1'b0;
			chans_q    <= '0;
			bps_q      <= '0;
			frame_q    <= '0;
			rate_q     <= '0;
			cur_ch_q   <= 1'b0;
			sidx_q     <= '0;
			low_q      <= '0;
			done_q     <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			ckind_q    <= ckind_d;
			pos_q      <= pos_d;
			shift_q    <= shift_d;
			rem_q      <= rem_d;
			fmt_seen_q <= fmt_seen_d;
			chans_q    <= chans_d;
			bps_q      <= bps_d;
			frame_q    <= frame_d;
			rate_q     <= rate_d;
			cur_ch_q   <= cur_ch_d;
			sidx_q     <= sidx_d;
			low_q      <= low_d;
			done_q     <= done_d;
		end
	end

endmodule

### hw/rtl/wps_back.sv
// Result back end: expands queued events into single results.
// Holds one result in an output register that the consumer pops.
// Depends on wps_pkg for the event record and result codes.
module wps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wps_pkg::event_t    ev,
	input  logic               ev_empty,
	output logic               ev_pop,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         kind,
	output logic signed [15:0] sample_value,
	output logic               channel,
	output logic [31:0]        sample_rate,
	output logic [1:0]         channel_count,
	output logic [15:0]        sample_bits,
	output logic [1:0]         status,
	output logic               last
);

	logic               out_valid_q;
	logic               tail_q;
	logic               tail_d;
	logic               take;
	logic               send_status;
	logic [1:0]         kind_q;
	logic signed [15:0] value_q;
	logic               chan_q;
	logic [31:0]        rate_q;
	logic [1:0]         chans_q;
	logic [15:0]        bits_q;
	logic [1:0]         status_q;
	logic               last_q;

	assign empty         = !out_valid_q;
	assign kind          = kind_q;
	assign sample_value  = value_q;
	assign channel       = chan_q;
	assign sample_rate   = rate_q;
	assign channel_count = chans_q;
	assign sample_bits   = bits_q;
	assign status        = status_q;
	assign last          = last_q;

	// Pick the next result: the sample or report first, then the status
	always_comb begin
		take        = !ev_empty && (!out_valid_q || pop);
		send_status = tail_q || !ev.prim_valid;
		ev_pop      = 1'b0;
		tail_d      = tail_q;
		if (take) begin
			if (send_status) begin
				ev_pop = 1'b1;
				tail_d = 1'b0;
			end else if (ev.st_valid) begin
				tail_d = 1'b1;
			end else begin
				ev_pop = 1'b1;
			end
		end
	end

	// Hold the valid flag and the tail marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tail_q      <= 1'b0;
		end else begin
			tail_q <= tail_d;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (take) begin
			if (send_status) begin
				kind_q   <= wps_pkg::KIND_STATUS;
				value_q  <= '0;
				chan_q   <= 1'b0;
				rate_q   <= '0;
				chans_q  <= '0;
				bits_q   <= '0;
				status_q <= ev.st;
				last_q   <= 1'b1;
			end else begin
				kind_q   <= ev.prim_kind;
				value_q  <= ev.value;
				chan_q   <= ev.chan;
				rate_q   <= ev.rate;
				chans_q  <= ev.chans;
				bits_q   <= ev.bits;
				status_q <= '0;
				last_q   <= !ev.st_valid;
			end
		end
	end

endmodule

### hw/rtl/wav_pcm_stream_parser.sv
// Top level of the WAV PCM stream parser: front end, event queue, back end.
// Depends on wps_pkg, wps_front, wps_queue and wps_back.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+---------------------------------------------
//   input    | in        | push / full    | data_byte, start_of_file, end_of_file
//   results  | out       | pop / empty    | kind, sample_value, channel, sample_rate,
//            |           |                | channel_count, sample_bits, status, last
//
// One byte is accepted per cycle while the event queue has room; the front end
// updates its state in the same cycle and queues at most one event per byte.
// A result is registered once its event heads the queue and the output register
// is free or popped; a byte's two results (sample or report, then status) come in turn.
// full rises only when the QUEUE_DEPTH-entry event queue fills under result stall.
// arst_n clears all parser and queue state; no clearing pass is needed.
module wav_pcm_stream_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               start_of_file,
	input  logic               end_of_file,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         kind,
	output logic signed [15:0] sample_value,
	output logic               channel,
	output logic [31:0]        sample_rate,
	output logic [1:0]         channel_count,
	output logic [15:0]        sample_bits,
	output logic [1:0]         status,
	output logic               last
);

	logic            accept;
	logic            ev_valid;
	wps_pkg::event_t ev_in;
	wps_pkg::event_t ev_head;
	logic            ev_empty;
	logic            ev_pop;

	assign accept = push && !full;

	wps_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.end_of_file   (end_of_file),
		.ev_valid      (ev_valid),
		.ev            (ev_in)
	);

	wps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && ev_valid),
		.wr_data (ev_in),
		.full    (full),
		.rd_en   (ev_pop),
		.rd_data (ev_head),
		.empty   (ev_empty)
	);

	wps_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev            (ev_head),
		.ev_empty      (ev_empty),
		.ev_pop        (ev_pop),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.sample_value  (sample_value),
		.channel       (channel),
		.sample_rate   (sample_rate),
		.channel_count (channel_count),
		.sample_bits   (sample_bits),
		.status        (status),
		.last          (last)
	);

endmodule

### hw/rtl/wps_checker.sv
// Port-level checks on the result side of the WAV PCM stream parser.
// Depends on wps_pkg for result codes; bound to wav_pcm_stream_parser below.
module wps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [1:0]         kind,
	input logic signed [15:0] sample_value,
	input logic               channel,
	input logic [31:0]        sample_rate,
	input logic [1:0]         channel_count,
	input logic [15:0]        sample_bits,
	input logic [1:0]         status,
	input logic               last
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(sample_value) &&
			$stable(status) && $stable(last)))
		else $error("stalled result changed");

	// Keep format and status fields clear on samples
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == wps_pkg::KIND_SAMPLE) |->
			(sample_rate == '0 && channel_count == '0 && sample_bits == '0 && status == '0))
		else $error("sample carries foreign fields");

	// Report only accepted formats
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == wps_pkg::KIND_REPORT) |->
			((channel_count == 2'd1 || channel_count == 2'd2) &&
			 sample_bits != '0 && sample_bits[2:0] == 3'd0 && sample_value == '0))
		else $error("format report out of range");

	// End every step with the status when one is given
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == wps_pkg::KIND_STATUS) |-> (last && !channel))
		else $error("status result not last");

endmodule

bind wav_pcm_stream_parser wps_checker u_wps_checker (.*);

### tb/wps_result_checker.sv
// Result checker for the WAV PCM stream parser: predicts the results of every
// accepted request from its own copy of the parser state and compares them in order.
// Depends on wps_pkg.
`timescale 1ns / 1ps

module wps_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	input  logic        end_of_file,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [15:0] sample_value,
	input  logic        channel,
	input  logic [31:0] sample_rate,
	input  logic [1:0]  channel_count,
	input  logic [15:0] sample_bits,
	input  logic [1:0]  status,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          n_samples,
	output int          n_reports,
	output int          n_statuses
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic        chan;
		logic [31:0] rate;
		logic [1:0]  chans;
		logic [15:0] bits;
		logic [1:0]  st;
		logic        last;
	} wav_result_t;

	localparam logic [7:0] RIFF_ID [4] = '{"R", "I", "F", "F"};
	localparam logic [7:0] WAVE_ID [4] = '{"W", "A", "V", "E"};
	localparam logic [7:0] FMT_ID  [4] = '{"f", "m", "t", " "};
	localparam logic [7:0] DATA_ID [4] = '{"d", "a", "t", "a"};

	// Parser state as the byte stream has left it
	wps_pkg::phase_t ph;
	logic [4:0]  at_byte;
	logic [31:0] shreg;
	logic [31:0] left;
	wps_pkg::chunk_t chunk;
	logic        fmt_ok;
	logic [1:0]  n_ch;
	logic [12:0] bytes_per;
	logic [31:0] rate_hold;
	logic        ch_now;
	logic [12:0] in_sample;
	logic [7:0]  lo_hold;
	logic        done;

	wav_result_t step_q[$];
	wav_result_t parsed_q[$];
	wav_result_t head;
	int fails, samples, reports, statuses;

	function automatic void clear_parser();
		ph = wps_pkg::PH_RIFF;
		at_byte = '0;
		shreg = '0;
		left = '0;
		chunk = wps_pkg::CK_OTHER;
		fmt_ok = 1'b0;
		n_ch = '0;
		bytes_per = '0;
		rate_hold = '0;
		ch_now = 1'b0;
		in_sample = '0;
		lo_hold = '0;
		done = 1'b0;
	endfunction

	function automatic void add_status(wps_pkg::status_t s);
		wav_result_t r;
		r = '0;
		r.kind = wps_pkg::KIND_STATUS;
		r.st = s;
		step_q.push_back(r);
		done = 1'b1;
	endfunction

	function automatic void add_sample(logic [15:0] v);
		wav_result_t r;
		r = '0;
		r.kind = wps_pkg::KIND_SAMPLE;
		r.value = v;
		r.chan = ch_now;
		step_q.push_back(r);
	endfunction

	function automatic void add_report();
		wav_result_t r;
		r = '0;
		r.kind = wps_pkg::KIND_REPORT;
		r.rate = rate_hold;
		r.chans = n_ch;
		r.bits = {bytes_per, 3'b000};
		step_q.push_back(r);
	endfunction

	function automatic void next_chunk_id();
		ph = wps_pkg::PH_CID;
		at_byte = '0;
		chunk = wps_pkg::CK_OTHER;
	endfunction

	// Close a chunk header: open fmt, start data, or skip the chunk
	function automatic void close_header();
		logic [31:0] frame;
		if (chunk == wps_pkg::CK_FMT && !fmt_ok) begin
			if (shreg < 32'd16) begin
				add_status(wps_pkg::ST_UNREC);
			end else begin
				left = shreg;
				ph = wps_pkg::PH_FMT;
				at_byte = '0;
			end
		end else if (chunk == wps_pkg::CK_DATA) begin
			if (!fmt_ok) begin
				add_status(wps_pkg::ST_CORRUPT);
			end else begin
				frame = 32'(n_ch) * 32'(bytes_per);
				if (frame == 0) frame = 32'd1;
				left = (shreg / frame) * frame;
				add_report();
				if (left == 0) begin
					add_status(wps_pkg::ST_OK);
				end else begin
					ph = wps_pkg::PH_DATA;
					ch_now = 1'b0;
					in_sample = '0;
				end
			end
		end else begin
			left = shreg;
			if (shreg == 0) next_chunk_id();
			else ph = wps_pkg::PH_SKIP;
		end
	endfunction

	// Advance the parser by one accepted request and queue what it yields
	function automatic void parse_wav_byte(logic [7:0] b, logic sof, logic eof);
		logic [1:0]  p;
		logic [1:0]  nxt;
		logic [4:0]  fp;
		logic [15:0] half;
		logic [7:0]  centered;
		step_q.delete();
		if (sof) clear_parser();
		if (done) return;
		shreg = {b, shreg[31:8]};
		p = at_byte[1:0];
		nxt = p + 2'd1;
		case (ph)
			wps_pkg::PH_RIFF: begin
				if (b != RIFF_ID[p]) begin
					add_status(wps_pkg::ST_UNREC);
				end else begin
					at_byte = {3'b000, nxt};
					if (p == 2'd3) ph = wps_pkg::PH_FSIZE;
				end
			end
			wps_pkg::PH_FSIZE: begin
				at_byte = {3'b000, nxt};
				if (p == 2'd3) ph = wps_pkg::PH_WAVE;
			end
			wps_pkg::PH_WAVE: begin
				if (b != WAVE_ID[p]) begin
					add_status(wps_pkg::ST_UNREC);
				end else begin
					at_byte = {3'b000, nxt};
					if (p == 2'd3) next_chunk_id();
				end
			end
			wps_pkg::PH_CID: begin
				if (p == 2'd0)
					chunk = (b == FMT_ID[0]) ? wps_pkg::CK_FMT :
						(b == DATA_ID[0]) ? wps_pkg::CK_DATA : wps_pkg::CK_OTHER;
				else if (chunk == wps_pkg::CK_FMT && b != FMT_ID[p])
					chunk = wps_pkg::CK_OTHER;
				else if (chunk == wps_pkg::CK_DATA && b != DATA_ID[p])
					chunk = wps_pkg::CK_OTHER;
				at_byte = {3'b000, nxt};
				if (p == 2'd3) ph = wps_pkg::PH_CSIZE;
			end
			wps_pkg::PH_CSIZE: begin
				at_byte = {3'b000, nxt};
				if (p == 2'd3) close_header();
			end
			wps_pkg::PH_FMT: begin
				fp = at_byte;
				half = shreg[31:16];
				left = left - 32'd1;
				at_byte = fp + 5'd1;
				// format code, channel count and sample width end on these bytes
				if (fp == 5'd1 && half != 16'd1) begin
					add_status(wps_pkg::ST_UNREC);
				end else if (fp == 5'd3 && half != 16'd1 && half != 16'd2) begin
					add_status(wps_pkg::ST_UNREC);
				end else if (fp == 5'd15 && (half == 16'd0 || half[2:0] != 3'd0)) begin
					add_status(wps_pkg::ST_UNREC);
				end else begin
					if (fp == 5'd3) n_ch = half[1:0];
					if (fp == 5'd7) rate_hold = shreg;
					if (fp == 5'd15) begin
						bytes_per = half[15:3];
						fmt_ok = 1'b1;
						if (left == 0) next_chunk_id();
						else ph = wps_pkg::PH_SKIP;
					end
				end
			end
			wps_pkg::PH_SKIP: begin
				left = left - 32'd1;
				if (left == 0) next_chunk_id();
			end
			wps_pkg::PH_DATA: begin
				left = left - 32'd1;
				centered = b ^ 8'h80;
				if (bytes_per == 13'd1) add_sample({{8{centered[7]}}, centered});
				else if (in_sample == 13'd0) lo_hold = b;
				else if (in_sample == 13'd1) add_sample({b, lo_hold});
				// wrap to the next sample and, for stereo, the other channel
				if (int'(in_sample) + 1 >= int'(bytes_per)) begin
					in_sample = '0;
					if (n_ch == 2'd2) ch_now = ~ch_now;
				end else begin
					in_sample = in_sample + 13'd1;
				end
				if (left == 0) add_status(wps_pkg::ST_OK);
			end
		endcase
		if (!done && eof)
			add_status((ph <= wps_pkg::PH_WAVE) ? wps_pkg::ST_UNREC : wps_pkg::ST_CORRUPT);
		foreach (step_q[i]) begin
			head = step_q[i];
			head.last = (i == step_q.size() - 1);
			parsed_q.push_back(head);
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			parsed_q.delete();
			fails = 0;
			samples = 0;
			reports = 0;
			statuses = 0;
		end else begin
			// predict the accepted request before looking at the result side
			if (push && !full) parse_wav_byte(data_byte, start_of_file, end_of_file);
			// match the delivered result against the oldest prediction
			if (pop && !empty) begin
				if (parsed_q.size() == 0) begin
					$error("result with nothing expected: kind %0d", kind);
					fails++;
				end else begin
					head = parsed_q.pop_front();
					compare_field("kind", 32'(head.kind), 32'(kind));
					compare_field("sample_value", 32'(head.value), 32'(sample_value));
					compare_field("channel", 32'(head.chan), 32'(channel));
					compare_field("sample_rate", head.rate, sample_rate);
					compare_field("channel_count", 32'(head.chans), 32'(channel_count));
					compare_field("sample_bits", 32'(head.bits), 32'(sample_bits));
					compare_field("status", 32'(head.st), 32'(status));
					compare_field("last", 32'(head.last), 32'(last));
					if (head.kind == wps_pkg::KIND_SAMPLE) samples++;
					else if (head.kind == wps_pkg::KIND_REPORT) reports++;
					else statuses++;
				end
			end
		end
		errors <= fails;
		pending <= parsed_q.size();
		n_samples <= samples;
		n_reports <= reports;
		n_statuses <= statuses;
	end

endmodule

### tb/wav_pcm_stream_parser_tb.sv
// Testbench top for the WAV PCM stream parser: builds WAV files byte by byte,
// drives them with random idling on both sides and gives the verdict.
// Depends on wps_pkg, wav_pcm_stream_parser and wps_result_checker.
`timescale 1ns / 1ps

module wav_pcm_stream_parser_tb;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_BYTES = 120;
	localparam int SETTLE       = 16;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         data_byte = 8'd0;
	logic               start_of_file = 1'b0;
	logic               end_of_file = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic [1:0]         kind;
	logic signed [15:0] sample_value;
	logic               channel;
	logic [31:0]        sample_rate;
	logic [1:0]         channel_count;
	logic [15:0]        sample_bits;
	logic [1:0]         status;
	logic               last;

	int errors, pending, n_samples, n_reports, n_statuses;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles;
	int bytes_sent = 0;
	int files_sent = 0;
	logic [7:0] wav_bytes[$];

	wav_pcm_stream_parser i_dut (.*);

	wps_result_checker i_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk) pop <= ($urandom_range(99) >= recv_stall_pct);

	// Count cycles in which no request moves on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) quiet_cycles <= 0;
		else if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("timeout: no request moved for %0d cycles", STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic put_le(logic [31:0] v, int n);
		for (int i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
	endtask

	task automatic put_id(logic [31:0] id);
		for (int i = 3; i >= 0; i--) wav_bytes.push_back(id[8*i +: 8]);
	endtask

	task automatic start_file();
		wav_bytes.delete();
		put_id("RIFF");
		put_le($urandom, 4);
		put_id("WAVE");
	endtask

	task automatic put_fmt(int size, logic [15:0] code, logic [15:0] chans,
			logic [31:0] rate, logic [15:0] bits);
		logic [15:0] align;
		align = chans * (bits >> 3);
		put_id("fmt ");
		put_le(size, 4);
		if (size < 16) begin
			repeat (size) wav_bytes.push_back(8'($urandom));
		end else begin
			put_le(32'(code), 2);
			put_le(32'(chans), 2);
			put_le(rate, 4);
			put_le(rate * 32'(align), 4);
			put_le(32'(align), 2);
			put_le(32'(bits), 2);
			repeat (size - 16) wav_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic put_data(int size, int n);
		put_id("data");
		put_le(size, 4);
		repeat (n) wav_bytes.push_back(8'($urandom));
	endtask

	// Hold off a random number of cycles, then offer one request until taken
	task automatic send_byte(logic [7:0] b, logic sof, logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		start_of_file <= sof;
		end_of_file <= eof;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
	endtask

	// Send the first n bytes of the built file, flagging its start and optionally its end
	task automatic send_file(int n, bit with_eof);
		int cnt;
		cnt = (n < wav_bytes.size()) ? n : wav_bytes.size();
		for (int i = 0; i < cnt; i++)
			send_byte(wav_bytes[i], i == 0, with_eof && i == cnt - 1);
		files_sent++;
	endtask

	// Drop push and hold until every predicted result has been delivered
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_file();
		int unsigned chans, bits, pick, n;
		logic [31:0] rate;
		start_file();
		chans = $urandom_range(1, 2);
		pick = $urandom_range(19);
		if (pick < 8) bits = 8;
		else if (pick < 12) bits = 16;
		else if (pick < 14) bits = 24;
		else if (pick < 16) bits = 32;
		else if (pick < 19) bits = 8 * $urandom_range(1, 8);
		else bits = 65528;
		pick = $urandom_range(9);
		rate = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		// unknown chunk ahead of fmt, sometimes empty
		if ($urandom_range(3) == 0) begin
			put_id($urandom);
			n = $urandom_range(0, 5);
			put_le(n, 4);
			repeat (n) wav_bytes.push_back(8'($urandom));
		end
		put_fmt(($urandom_range(3) == 0) ? 16 + $urandom_range(1, 4) : 16, wps_pkg::PCM_CODE,
			16'(chans), rate, 16'(bits));
		// a second fmt chunk is skipped whatever it holds
		if ($urandom_range(4) == 0)
			put_fmt(16, 16'($urandom), 16'($urandom), $urandom, 16'($urandom));
		n = $urandom_range(0, 40);
		put_data(n, n);
		repeat ($urandom_range(0, 2)) wav_bytes.push_back(8'($urandom));
		pick = $urandom_range(99);
		if (pick < 70) begin
			send_file(wav_bytes.size(), 1'b1);
		end else if (pick < 80) begin
			wav_bytes[$urandom_range(wav_bytes.size() - 1)] = 8'($urandom);
			send_file(wav_bytes.size(), 1'b1);
		end else if (pick < 90) begin
			send_file($urandom_range(1, wav_bytes.size() - 1), 1'b1);
		end else if (pick < 95) begin
			send_file($urandom_range(1, wav_bytes.size() - 1), 1'b0);
		end else begin
			wav_bytes.delete();
			repeat ($urandom_range(1, 16)) wav_bytes.push_back(8'($urandom));
			if ($urandom_range(1)) wav_bytes[0] = "R";
			send_file(wav_bytes.size(), 1'b1);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad RIFF tag, then an early end inside the header
		wav_bytes.delete();
		put_id("RIFX");
		send_file(4, 1'b1);
		start_file();
		send_file(3, 1'b1);
		// bad WAVE tag
		wav_bytes.delete();
		put_id("RIFF");
		put_le(36, 4);
		put_id("WAVF");
		send_file(wav_bytes.size(), 1'b1);
		// data chunk before any fmt chunk
		start_file();
		put_data(4, 4);
		send_file(wav_bytes.size(), 1'b1);
		// rejected formats: compression, channels, widths, short fmt chunk
		start_file();
		put_fmt(16, 16'd3, 1, 8000, 8);
		send_file(wav_bytes.size(), 1'b1);
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 3, 8000, 8);
		send_file(wav_bytes.size(), 1'b1);
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 1, 8000, 12);
		send_file(wav_bytes.size(), 1'b1);
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 1, 8000, 0);
		send_file(wav_bytes.size(), 1'b1);
		start_file();
		put_fmt(14, wps_pkg::PCM_CODE, 1, 8000, 8);
		send_file(wav_bytes.size(), 1'b1);
		// 8-bit mono at the top rate with the extreme sample bytes
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 1, 32'hFFFF_FFFF, 8);
		put_id("data");
		put_le(4, 4);
		put_le(32'h7F80_FF00, 4);
		send_file(wav_bytes.size(), 1'b1);
		// 16-bit stereo behind an unknown chunk and a second fmt, odd byte left over
		start_file();
		put_id("LIST");
		put_le(3, 4);
		put_le(32'h00AB_CDEF, 3);
		put_fmt(18, wps_pkg::PCM_CODE, 2, 0, 16);
		put_fmt(16, 16'd3, 7, 5, 13);
		put_id("data");
		put_le(9, 4);
		put_le(32'h7FFF_8000, 4);
		put_le(32'hFFFF_0000, 4);
		put_le(32'h5A, 1);
		put_le(32'hC3, 1);
		send_file(wav_bytes.size(), 1'b1);
		// zero whole frames, then the widest sample width
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 2, 48000, 24);
		put_data(5, 5);
		send_file(wav_bytes.size(), 1'b1);
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 2, 44100, 65528);
		put_data(100, 2);
		send_file(wav_bytes.size(), 1'b1);
		// early end inside fmt, then inside data on a sample byte
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 1, 8000, 8);
		send_file(20, 1'b1);
		start_file();
		put_fmt(16, wps_pkg::PCM_CODE, 1, 8000, 8);
		put_data(6, 6);
		send_file(wav_bytes.size() - 3, 1'b1);
		drain_results();

		// random files under four idling mixes, draining between them
		for (int ph_idx = 0; ph_idx < 4; ph_idx++) begin
			send_idle_pct = (ph_idx == 1) ? 87 : (ph_idx == 3) ? 29 : 0;
			recv_stall_pct = (ph_idx == 2) ? 87 : (ph_idx == 3) ? 29 : 0;
			bytes_sent = 0;
			while (bytes_sent < RANDOM_BYTES / 4) random_file();
			drain_results();
		end

		repeat (SETTLE) @(posedge clk);
		$display("covered %0d files: %0d samples, %0d format reports, %0d final statuses",
			files_sent, n_samples, n_reports, n_statuses);
		$display("random part ran with no idling, sender idle, receiver stalled and both");
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
